>>> rtl/hsa_pkg.sv
package hsa_pkg;

  // Default number of slots in the table.
  localparam int unsigned SlotsDefault = 256;

  // Fixed widths of the transaction fields.
  localparam int unsigned SlotW    = 8;
  localparam int unsigned CountW   = 8;
  localparam int unsigned MarkOutW = 9;

  // Smallest occupancy row, as a power of two.
  localparam int unsigned MinRowBits = 4;

  typedef enum logic {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } hsa_op_e;

  typedef enum logic [1:0] {
    StatusDone    = 2'd0,
    StatusFull    = 2'd1,
    StatusInvalid = 2'd2
  } hsa_status_e;

  typedef struct packed {
    hsa_op_e           opcode;
    logic [SlotW-1:0]  slot;
  } hsa_in_t;

  typedef struct packed {
    logic [SlotW-1:0]    granted_slot;
    hsa_status_e         status;
    logic [CountW-1:0]   live_count;
    logic [MarkOutW-1:0] high_mark;
  } hsa_out_t;

endpackage

>>> rtl/handle_slot_allocator.sv
// Handle slot allocator.
// Requests arrive as transactions on the input channel (in_valid_i, in_ready_o, in_i): an
// allocate takes a slot, a free returns one, and a free of slot 0 empties the whole table.
// Every request yields exactly one result transaction on the output channel (out_valid_o,
// out_ready_i, out_o) carrying the granted slot, a status code, the live count and the
// high-water mark after the request.
// The occupancy map sits in a synchronous RAM organised as rows of RowW flags, and each
// allocate or free that changes the map is a read, modify and write-back of one row. The
// block works on one request at a time. An allocate below the high-water mark and a free
// that is not the top slot pass through StAlloc or StFree and then StEmit to the result
// register; an invalid free above the mark or a free of everything goes straight to
// StEmit. Once the mark has reached SLOTS, an allocate walks the rows one per cycle from
// row 0 until it finds a free flag. Freeing the top slot walks downwards one row per cycle
// past empty rows. The next request is accepted in the cycle after the result register is
// loaded.
// With the default of 256 slots there are 16 rows of 16 flags.
// Reset empties the table at once through one valid flag per row held in flip-flops, so
// no clearing pass is needed; the mark returns to 1 and the count to 0.
// If the receiver stalls, a finished result waits in an internal stage until the result
// register is free, and no new request is accepted in the meantime.
module handle_slot_allocator import hsa_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  hsa_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output hsa_out_t out_o
);

  // Row geometry: rows grow for large tables so that there are never more than 256 rows.
  localparam int unsigned BitW = ($clog2(SLOTS) > MinRowBits + 8) ?
                                 ($clog2(SLOTS) - 8) : MinRowBits;
  localparam int unsigned RowW = 1 << BitW;
  localparam int unsigned Rows = (SLOTS + RowW - 1) / RowW;
  localparam int unsigned AW   = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned SW   = AW + BitW;
  localparam int unsigned MW   = SW + 1;

  localparam logic [MW-1:0] SlotsM   = MW'(SLOTS);
  localparam logic [AW-1:0] LastRow  = AW'(Rows - 1);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StAlloc = 6'b000010,
    StScan  = 6'b000100,
    StFree  = 6'b001000,
    StDrop  = 6'b010000,
    StEmit  = 6'b100000
  } hsa_state_e;

  hsa_state_e          state_q, state_d;
  logic [MW-1:0]       mark_q, mark_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [SW-1:0]       slot_q, slot_d;
  logic [AW-1:0]       row_q, row_d;
  logic [Rows-1:0]     row_vld_q, row_vld_d;
  logic [SlotW-1:0]    gnt_q, gnt_d;
  hsa_status_e         sts_q, sts_d;
  hsa_out_t            out_q, out_d;
  logic                out_vld_q, out_vld_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [RowW-1:0]     ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [RowW-1:0]     ram_rdata;

  logic [AW-1:0]       cur_addr;
  logic [RowW-1:0]     cur_row;
  logic [RowW-1:0]     legal;
  logic [RowW-1:0]     free_vec;
  logic [RowW-1:0]     slot_bit;
  logic [RowW-1:0]     cleared_row;
  logic [RowW-1:0]     hi_vec;
  logic [BitW-1:0]     lo_idx, hi_idx;
  logic                lo_found, hi_found;
  logic [SW+SlotW-1:0] in_slot_ext;
  logic [SW-1:0]       in_slot;
  logic [SW+SlotW-1:0] gnt_ext;
  logic [SW-1:0]       pick;
  logic [MW+MarkOutW-1:0] mark_ext;
  logic                can_emit;

  hsa_ram #(
    .Width (RowW),
    .Depth (Rows)
  ) u_occ_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  // Row whose read data is in use this cycle; a row without its valid flag reads as empty.
  assign cur_addr = (state_q == StAlloc || state_q == StFree) ? slot_q[SW-1:BitW] : row_q;
  assign cur_row  = row_vld_q[cur_addr] ? ram_rdata : '0;

  // Slot 0 and slots at or above SLOTS are never candidates during a scan.
  always_comb begin
    logic [SW-1:0] idx;
    legal = '0;
    for (int b = 0; b < RowW; b++) begin
      idx      = {row_q, BitW'(b)};
      legal[b] = (idx != '0) && ({1'b0, idx} < SlotsM);
    end
  end

  assign free_vec    = ~cur_row & legal;
  assign slot_bit    = RowW'(1) << slot_q[BitW-1:0];
  assign cleared_row = cur_row & ~slot_bit;
  assign hi_vec      = (state_q == StFree) ? cleared_row : cur_row;

  // Lowest free flag in the row being scanned.
  always_comb begin
    lo_idx   = '0;
    lo_found = 1'b0;
    for (int b = RowW - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        lo_idx   = BitW'(b);
        lo_found = 1'b1;
      end
    end
  end

  // Highest live flag, used when the mark drops past trailing free slots.
  always_comb begin
    hi_idx   = '0;
    hi_found = 1'b0;
    for (int b = 0; b < RowW; b++) begin
      if (hi_vec[b]) begin
        hi_idx   = BitW'(b);
        hi_found = 1'b1;
      end
    end
  end

  assign in_slot_ext = {{SW{1'b0}}, in_i.slot};
  assign in_slot     = in_slot_ext[SW-1:0];
  assign pick        = (state_q == StScan) ? {row_q, lo_idx} : slot_q;
  assign gnt_ext     = {{SlotW{1'b0}}, pick};
  assign mark_ext    = {{MarkOutW{1'b0}}, mark_q};
  assign can_emit    = !out_vld_q || out_ready_i;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  always_comb begin
    state_d   = state_q;
    mark_d    = mark_q;
    count_d   = count_q;
    slot_d    = slot_q;
    row_d     = row_q;
    row_vld_d = row_vld_q;
    gnt_d     = gnt_q;
    sts_d     = sts_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = cur_row;
    ram_raddr = row_q;

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          gnt_d = '0;
          sts_d = StatusDone;
          if (in_i.opcode == OpAlloc) begin
            if (mark_q < SlotsM) begin
              // Fast path: take the high-water mark.
              slot_d    = mark_q[SW-1:0];
              ram_raddr = mark_q[SW-1:BitW];
              mark_d    = mark_q + MW'(1);
              state_d   = StAlloc;
            end else begin
              row_d     = '0;
              ram_raddr = '0;
              state_d   = StScan;
            end
          end else if (in_i.slot == '0) begin
            // Free of everything: drop every row's valid flag at once.
            row_vld_d = '0;
            mark_d    = MW'(1);
            count_d   = '0;
            state_d   = StEmit;
          end else if ({{MW{1'b0}}, in_i.slot} < {{SlotW{1'b0}}, mark_q}) begin
            slot_d    = in_slot;
            ram_raddr = in_slot[SW-1:BitW];
            state_d   = StFree;
          end else begin
            sts_d   = StatusInvalid;
            state_d = StEmit;
          end
        end
      end

      StAlloc: begin
        ram_we              = 1'b1;
        ram_wdata           = cur_row | slot_bit;
        row_vld_d[cur_addr] = 1'b1;
        count_d             = count_q + CountW'(1);
        gnt_d               = gnt_ext[SlotW-1:0];
        state_d             = StEmit;
      end

      StScan: begin
        if (lo_found) begin
          ram_we              = 1'b1;
          ram_wdata           = cur_row | (RowW'(1) << lo_idx);
          row_vld_d[cur_addr] = 1'b1;
          count_d             = count_q + CountW'(1);
          gnt_d               = gnt_ext[SlotW-1:0];
          state_d             = StEmit;
        end else if (row_q == LastRow) begin
          sts_d   = StatusFull;
          state_d = StEmit;
        end else begin
          row_d     = row_q + AW'(1);
          ram_raddr = row_q + AW'(1);
        end
      end

      StFree: begin
        if ((cur_row & slot_bit) == '0) begin
          sts_d   = StatusInvalid;
          state_d = StEmit;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = cleared_row;
          count_d   = count_q - CountW'(1);
          state_d   = StEmit;
          if ({1'b0, slot_q} + MW'(1) == mark_q) begin
            // The top slot went free: everything above it is free already, so the
            // new mark sits just past the highest live slot below.
            if (hi_found) begin
              mark_d = {1'b0, slot_q[SW-1:BitW], hi_idx} + MW'(1);
            end else if (slot_q[SW-1:BitW] == '0) begin
              mark_d = MW'(1);
            end else begin
              row_d     = slot_q[SW-1:BitW] - AW'(1);
              ram_raddr = slot_q[SW-1:BitW] - AW'(1);
              state_d   = StDrop;
            end
          end
        end
      end

      StDrop: begin
        if (hi_found) begin
          mark_d  = {1'b0, row_q, hi_idx} + MW'(1);
          state_d = StEmit;
        end else if (row_q == '0) begin
          mark_d  = MW'(1);
          state_d = StEmit;
        end else begin
          row_d     = row_q - AW'(1);
          ram_raddr = row_q - AW'(1);
        end
      end

      StEmit: begin
        if (can_emit) begin
          out_d.granted_slot = gnt_q;
          out_d.status       = sts_q;
          out_d.live_count   = count_q;
          out_d.high_mark    = mark_ext[MarkOutW-1:0];
          out_vld_d          = 1'b1;
          state_d            = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      mark_q    <= MW'(1);
      count_q   <= '0;
      row_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mark_q    <= mark_d;
      count_q   <= count_d;
      row_vld_q <= row_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    row_q  <= row_d;
    gnt_q  <= gnt_d;
    sts_q  <= sts_d;
    out_q  <= out_d;
  end

endmodule

>>> rtl/hsa_ram.sv
module hsa_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      wr_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  logic [Width-1:0]                          wr_data_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output logic [Width-1:0]                          rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Single write port and one registered read port; no reset on the array.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> bench/testbench.sv
module testbench;
  import hsa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The bench runs the block at its default size of 256 slots.
  localparam int NumSlots    = SlotsDefault;
  localparam int NumDirected = 22;
  localparam int RandomItems = 1400;
  // A top-slot free can walk down every row of the occupancy map, so the drain
  // at the end leaves room for a walk over every row.
  localparam int DrainCycles = 40;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     req_valid = 1'b0;
  logic     req_ready;
  hsa_in_t  req_data = '0;
  logic     res_valid;
  logic     res_ready = 1'b0;
  hsa_out_t res_data;

  handle_slot_allocator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_ready_o (req_ready),
    .in_i       (req_data),
    .out_valid_o(res_valid),
    .out_ready_i(res_ready),
    .out_o      (res_data)
  );

  // The clock has a period of 20 ns.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the allocator: one live flag per slot, the high-water mark and
  // the live count. It is advanced once for every request transaction that the
  // block accepts, in the order of acceptance.
  bit       slot_live [NumSlots];
  int       water_mark = 1;
  int       live_slots = 0;

  // Results still owed by the block, oldest first.
  hsa_out_t owed_results [$];
  int       fail_count = 0;

  // When idling is switched off, neither side inserts gaps, which gives stretches
  // of back-to-back traffic between the stretches with random gaps.
  bit       idle_on = 1'b1;
  int       stall_left = 0;

  // One row of the directed table. Where the expected result can be read off at a
  // glance it is written into the row; otherwise the shadow copy supplies it.
  typedef struct packed {
    hsa_op_e  op;
    logic [SlotW-1:0] slot;
    logic     typed;
    hsa_out_t res;
  } dir_row_t;

  dir_row_t directed_rows [NumDirected];

  // Applies one request to the shadow copy and returns the result that the block
  // ought to produce for it.
  function automatic hsa_out_t apply_request(hsa_in_t req);
    hsa_out_t res;
    int       pick;
    int       idx;
    res = '0;
    res.status = StatusDone;
    if (req.opcode == OpAlloc) begin
      pick = 0;
      if (water_mark >= NumSlots) begin
        // The mark has reached the end of the table, so the lowest free slot
        // from 1 upward is taken; slot 0 is never handed out.
        idx = 1;
        while (idx < NumSlots && slot_live[idx]) idx++;
        if (idx < NumSlots) pick = idx;
      end else begin
        pick = water_mark;
        water_mark++;
      end
      if (pick == 0) begin
        res.status = StatusFull;
      end else begin
        slot_live[pick] = 1'b1;
        live_slots = (live_slots + 1) % 256;
        res.granted_slot = pick[SlotW-1:0];
      end
    end else if (req.slot == 0) begin
      // A free of slot 0 empties the whole table.
      slot_live = '{default: 1'b0};
      water_mark = 1;
      live_slots = 0;
    end else if (int'(req.slot) < water_mark && slot_live[req.slot]) begin
      slot_live[req.slot] = 1'b0;
      // Freeing the top slot pulls the mark down past every trailing free slot,
      // but the mark never goes below 1.
      if (int'(req.slot) == water_mark - 1) begin
        while (water_mark > 1 && !slot_live[water_mark - 1]) water_mark--;
      end
      live_slots = (live_slots + 255) % 256;
    end else begin
      res.status = StatusInvalid;
    end
    res.live_count = live_slots[CountW-1:0];
    res.high_mark = water_mark[MarkOutW-1:0];
    return res;
  endfunction

  // Gap length for either side: mostly none or short, occasionally long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Builds one random request. Most frees target a slot that is live, so that the
  // deep behaviour (scans, mark drops) is reached; the rest are noise.
  function automatic hsa_in_t make_request(int alloc_pct);
    hsa_in_t req;
    int      live_list [$];
    int      r;
    req.opcode = OpAlloc;
    req.slot = SlotW'($urandom());
    if ($urandom_range(0, 99) < alloc_pct) return req;
    req.opcode = OpFree;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      for (int i = 1; i < NumSlots; i++) begin
        if (slot_live[i]) live_list.push_back(i);
      end
      if (live_list.size() != 0) begin
        req.slot = SlotW'(live_list[$urandom_range(0, live_list.size() - 1)]);
      end else begin
        req.slot = SlotW'($urandom_range(1, NumSlots - 1));
      end
    end else if (r < 80 && water_mark > 1) begin
      req.slot = SlotW'(water_mark - 1);
    end else if (r < 98) begin
      req.slot = SlotW'($urandom_range(1, NumSlots - 1));
    end else begin
      req.slot = '0;
    end
    return req;
  endfunction

  // Presents one request transaction and holds it until it is accepted. The task
  // is entered and left at a falling edge, so each input changes only there.
  task automatic send_request(hsa_in_t req, logic typed, hsa_out_t typed_res);
    int       gap;
    hsa_out_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data <= req;
    do @(posedge clk); while (!req_ready);
    predicted = apply_request(req);
    owed_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // Holds the sender off until every owed result has arrived.
  task automatic wait_for_quiet();
    req_valid <= 1'b0;
    do @(negedge clk); while (owed_results.size() != 0);
  endtask

  task automatic compare_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s expected %0d actual %0d", $realtime, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // The receiver lowers ready for random stretches, changing it only at a
  // falling edge.
  always @(negedge clk) begin
    if (!idle_on) begin
      res_ready <= 1'b1;
    end else if (stall_left > 0) begin
      res_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      res_ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Every result transaction is checked against the oldest owed result.
  always @(posedge clk) begin
    hsa_out_t exp_res;
    if (rst_n && res_valid && res_ready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result with nothing owed, actual slot %0d status %0d", $realtime,
                 res_data.granted_slot, res_data.status);
        fail_count++;
      end else begin
        exp_res = owed_results.pop_front();
        compare_field("granted_slot", exp_res.granted_slot, res_data.granted_slot);
        compare_field("status", exp_res.status, res_data.status);
        compare_field("live_count", exp_res.live_count, res_data.live_count);
        compare_field("high_mark", exp_res.high_mark, res_data.high_mark);
      end
    end
  end

  initial begin
    hsa_in_t req;
    int      sent;
    int      phase_len;
    int      alloc_pct;
    int      waited;

    // Directed part: after reset, the extremes of the slot field, invalid frees
    // above the mark and below it, freeing the top slot with and without a
    // drop past trailing free slots, the mark floor at 1, and freeing everything.
    directed_rows = '{
      '{OpAlloc, 8'h00, 1'b1, '{8'd1, StatusDone,    8'd1, 9'd2}},
      '{OpAlloc, 8'hFF, 1'b1, '{8'd2, StatusDone,    8'd2, 9'd3}},
      '{OpFree,  8'h05, 1'b1, '{8'd0, StatusInvalid, 8'd2, 9'd3}},
      '{OpFree,  8'hFF, 1'b1, '{8'd0, StatusInvalid, 8'd2, 9'd3}},
      '{OpFree,  8'h02, 1'b1, '{8'd0, StatusDone,    8'd1, 9'd2}},
      '{OpFree,  8'h02, 1'b1, '{8'd0, StatusInvalid, 8'd1, 9'd2}},
      '{OpAlloc, 8'h00, 1'b0, '0},
      '{OpAlloc, 8'h00, 1'b0, '0},
      '{OpFree,  8'h02, 1'b1, '{8'd0, StatusDone,    8'd2, 9'd4}},
      '{OpFree,  8'h02, 1'b1, '{8'd0, StatusInvalid, 8'd2, 9'd4}},
      '{OpFree,  8'h03, 1'b1, '{8'd0, StatusDone,    8'd1, 9'd2}},
      '{OpFree,  8'h01, 1'b1, '{8'd0, StatusDone,    8'd0, 9'd1}},
      '{OpFree,  8'h01, 1'b1, '{8'd0, StatusInvalid, 8'd0, 9'd1}},
      '{OpFree,  8'h00, 1'b1, '{8'd0, StatusDone,    8'd0, 9'd1}},
      '{OpAlloc, 8'hAA, 1'b0, '0},
      '{OpAlloc, 8'h55, 1'b0, '0},
      '{OpAlloc, 8'h00, 1'b0, '0},
      '{OpFree,  8'h00, 1'b1, '{8'd0, StatusDone,    8'd0, 9'd1}},
      '{OpAlloc, 8'h00, 1'b1, '{8'd1, StatusDone,    8'd1, 9'd2}},
      '{OpFree,  8'hAA, 1'b1, '{8'd0, StatusInvalid, 8'd1, 9'd2}},
      '{OpFree,  8'h55, 1'b1, '{8'd0, StatusInvalid, 8'd1, 9'd2}},
      '{OpFree,  8'h00, 1'b1, '{8'd0, StatusDone,    8'd0, 9'd1}}
    };

    // Reset is held and then released at a falling edge.
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NumDirected; i++) begin
      req.opcode = directed_rows[i].op;
      req.slot = directed_rows[i].slot;
      send_request(req, directed_rows[i].typed, directed_rows[i].res);
    end
    wait_for_quiet();

    // Random part in phases. The first phase fills the table to the end and
    // beyond, so that the full case and the scan for the lowest free slot are
    // reached early; later phases lean towards filling, mixing or draining.
    sent = 0;
    phase_len = 262;
    alloc_pct = 100;
    while (sent < RandomItems) begin
      for (int i = 0; i < phase_len; i++) begin
        send_request(make_request(alloc_pct), 1'b0, '0);
        sent++;
      end
      if ($urandom_range(0, 2) == 0) wait_for_quiet();
      phase_len = $urandom_range(50, 300);
      case ($urandom_range(0, 2))
        0: begin
          alloc_pct = 97;
        end
        1: begin
          alloc_pct = 60;
        end
        default: begin
          alloc_pct = 30;
        end
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
    end

    req_valid <= 1'b0;
    idle_on = 1'b1;
    waited = 0;
    while (owed_results.size() != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    repeat (DrainCycles) @(negedge clk);
    if (owed_results.size() != 0) begin
      $display("%0t: %0d results expected but never received", $realtime,
               owed_results.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("handle_slot_allocator: match");
    end else begin
      $display("handle_slot_allocator: mismatch");
    end
    $finish;
  end

  // Safety net for a hung handshake: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("handle_slot_allocator: mismatch");
    $finish;
  end

endmodule

>>> files.f
rtl/hsa_pkg.sv
rtl/hsa_ram.sv
rtl/handle_slot_allocator.sv
bench/testbench.sv
